// ===== hdl/range_letter_histogram_difference_defines.svh =====
// Assertion macros used by the top-level RTL.
`ifndef RANGE_LETTER_HISTOGRAM_DIFFERENCE_DEFINES_SVH
`define RANGE_LETTER_HISTOGRAM_DIFFERENCE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define RLHD_ASSERT_NOW(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define RLHD_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error(msg);

`endif

// ===== hdl/rlhd_pkg.sv =====
package rlhd_pkg;

    localparam int MAX_LENGTH    = 1024;
    localparam int ALPHABET_SIZE = 26;
    localparam int ADDR_W        = $clog2(MAX_LENGTH);
    localparam int POS_W         = 11;
    localparam int CNT_W         = 11;
    localparam int LTR_W         = 5;
    localparam int GRP_SIZE      = 8;
    localparam int NUM_GRP       = (ALPHABET_SIZE + GRP_SIZE - 1) / GRP_SIZE;
    localparam int FIFO_DEPTH    = 2;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [LTR_W-1:0] letter_a;
        logic [LTR_W-1:0] letter_b;
        logic [POS_W-1:0] range_lo;
        logic [POS_W-1:0] range_hi;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] difference;
        logic             status;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_QUERY,
        OP_ERROR
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [LTR_W-1:0]  la;
        logic [LTR_W-1:0]  lb;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] hi_addr;
        logic [ADDR_W-1:0] lo_addr;
        logic              lo_zero;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_LO,
        BK_DIFF,
        BK_SUM1,
        BK_SUM2
    } t_back_state;

endpackage

// ===== hdl/range_letter_histogram_difference.sv =====
// Items are queued, popped in IDLE and run from EXEC; results are registered.
// One at a time: EXEC on clear/append/error; EXEC, LO, DIFF, SUM1, SUM2 on a query
// (hi read, lo read, per-letter diff, group sums, total); a 2-entry queue buffers.
// busy rises only when that queue is full; results cannot be stalled by the receiver.
// Synchronous active-low reset empties the queue, zeroes length and running counts;
// prefix banks are not cleared, only positions written since the last clear are read.
module range_letter_histogram_difference
    import rlhd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);

    `include "range_letter_histogram_difference_defines.svh"

    t_fifo_stat fifo_stat;
    t_cmd       push_cmd;
    t_cmd       head_cmd;
    logic       push;
    logic       pop;

    // Front: range/length checks, position bookkeeping, item classification.
    rlhd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_fifo  (fifo_stat),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // Short command queue decoupling front and back.
    rlhd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (fifo_stat)
    );

    // Back: prefix bank writes and the query datapath.
    rlhd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_cmd),
        .i_fifo   (fifo_stat),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    assign busy = fifo_stat.full;

    `RLHD_ASSERT_NEXT(a_strobe_gap, i_clk, i_rst_n, o_strobe, !o_strobe, "back-to-back results")
    `RLHD_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, push, !fifo_stat.full, "queue overflow")
    `RLHD_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_strobe && o_result.status,
        o_result.difference == '0, "error result with nonzero difference")

endmodule

// ===== hdl/rlhd_ram.sv =====
module rlhd_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/rlhd_front.sv =====
module rlhd_front
    import rlhd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_in_item   i_item,
    input  t_fifo_stat i_fifo,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [POS_W-1:0] r_len;
    logic [POS_W-1:0] n_len;
    logic             accept;
    logic             app_bad;
    logic             qry_bad;
    logic [POS_W-1:0] hi_m1;
    logic [POS_W-1:0] lo_m2;

    assign accept  = i_start && !i_fifo.full;
    assign app_bad = (r_len >= POS_W'(MAX_LENGTH))
                  || (32'(i_item.letter_a) >= ALPHABET_SIZE)
                  || (32'(i_item.letter_b) >= ALPHABET_SIZE);
    assign qry_bad = (i_item.range_lo == '0) || (i_item.range_lo > i_item.range_hi)
                  || (i_item.range_hi > r_len);
    assign hi_m1   = i_item.range_hi - POS_W'(1);
    assign lo_m2   = i_item.range_lo - POS_W'(2);

    always_comb begin
        o_push          = 1'b0;
        n_len           = r_len;
        o_cmd.op        = OP_ERROR;
        o_cmd.la        = i_item.letter_a;
        o_cmd.lb        = i_item.letter_b;
        o_cmd.wr_addr   = r_len[ADDR_W-1:0];
        o_cmd.hi_addr   = hi_m1[ADDR_W-1:0];
        o_cmd.lo_addr   = lo_m2[ADDR_W-1:0];
        o_cmd.lo_zero   = (i_item.range_lo == POS_W'(1));
        unique case (i_item.mode)
            MODE_CLEAR: begin
                o_push   = accept;
                o_cmd.op = OP_CLEAR;
                n_len    = '0;
            end
            MODE_APPEND: begin
                o_push = accept;
                if (!app_bad) begin
                    o_cmd.op = OP_APPEND;
                    n_len    = r_len + POS_W'(1);
                end
            end
            MODE_QUERY: begin
                o_push = accept;
                if (!qry_bad) begin
                    o_cmd.op = OP_QUERY;
                end
            end
            default: o_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (o_push) begin
            r_len <= n_len;
        end
    end

endmodule

// ===== hdl/rlhd_fifo.sv =====
module rlhd_fifo
    import rlhd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd       i_cmd,
    input  logic       i_pop,
    output t_cmd       o_head,
    output t_fifo_stat o_stat
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_cmd          r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CW'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (32'(r_wp) == FIFO_DEPTH - 1) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (32'(r_rp) == FIFO_DEPTH - 1) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

// ===== hdl/rlhd_back.sv =====
module rlhd_back
    import rlhd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_fifo_stat i_fifo,
    output logic       o_pop,
    output logic       o_strobe,
    output t_out_item  o_result
);

    t_back_state       r_state;
    t_back_state       n_state;
    t_cmd              r_cmd;
    logic [CNT_W-1:0]  r_run_a [ALPHABET_SIZE];
    logic [CNT_W-1:0]  r_run_b [ALPHABET_SIZE];
    logic [CNT_W-1:0]  n_run_a [ALPHABET_SIZE];
    logic [CNT_W-1:0]  n_run_b [ALPHABET_SIZE];
    logic [CNT_W-1:0]  r_hi_a  [ALPHABET_SIZE];
    logic [CNT_W-1:0]  r_hi_b  [ALPHABET_SIZE];
    logic [CNT_W-1:0]  rd_a    [ALPHABET_SIZE];
    logic [CNT_W-1:0]  rd_b    [ALPHABET_SIZE];
    logic [CNT_W-1:0]  r_diff  [ALPHABET_SIZE];
    logic [CNT_W-1:0]  n_diff  [ALPHABET_SIZE];
    logic [CNT_W-1:0]  r_grp   [NUM_GRP];
    logic [CNT_W-1:0]  n_grp   [NUM_GRP];
    logic [CNT_W-1:0]  n_total;
    logic              we;
    logic [ADDR_W-1:0] raddr;
    logic              n_strobe;
    t_out_item         n_result;
    logic              r_strobe;
    t_out_item         r_result;

    // Next running counts for an append.
    always_comb begin
        for (int c = 0; c < ALPHABET_SIZE; c++) begin
            n_run_a[c] = r_run_a[c] + CNT_W'(32'(r_cmd.la) == c);
            n_run_b[c] = r_run_b[c] + CNT_W'(32'(r_cmd.lb) == c);
        end
    end

    // One bank per letter and string, all read at the same position.
    for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_bank
        rlhd_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LENGTH)) u_ram_a (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (r_cmd.wr_addr),
            .i_wdata (n_run_a[g]),
            .i_raddr (raddr),
            .o_rdata (rd_a[g])
        );
        rlhd_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LENGTH)) u_ram_b (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (r_cmd.wr_addr),
            .i_wdata (n_run_b[g]),
            .i_raddr (raddr),
            .o_rdata (rd_b[g])
        );
    end

    // Per-letter surplus of A over B; lower prefix reads as zero at position 0.
    always_comb begin
        logic [CNT_W-1:0] lo_a;
        logic [CNT_W-1:0] lo_b;
        logic [CNT_W-1:0] ca;
        logic [CNT_W-1:0] cb;
        for (int c = 0; c < ALPHABET_SIZE; c++) begin
            lo_a      = r_cmd.lo_zero ? '0 : rd_a[c];
            lo_b      = r_cmd.lo_zero ? '0 : rd_b[c];
            ca        = r_hi_a[c] - lo_a;
            cb        = r_hi_b[c] - lo_b;
            n_diff[c] = (ca > cb) ? ca - cb : '0;
        end
    end

    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++) begin
                if (g * GRP_SIZE + k < ALPHABET_SIZE) begin
                    n_grp[g] = n_grp[g] + r_diff[g * GRP_SIZE + k];
                end
            end
        end
        n_total = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            n_total = n_total + r_grp[g];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (!i_fifo.empty) n_state = BK_EXEC;
            BK_EXEC: n_state = (r_cmd.op == OP_QUERY) ? BK_LO : BK_IDLE;
            BK_LO:   n_state = BK_DIFF;
            BK_DIFF: n_state = BK_SUM1;
            BK_SUM1: n_state = BK_SUM2;
            BK_SUM2: n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_pop    = 1'b0;
        we       = 1'b0;
        raddr    = r_cmd.hi_addr;
        n_strobe = 1'b0;
        n_result = '0;
        unique case (r_state)
            BK_IDLE: o_pop = !i_fifo.empty;
            BK_EXEC: begin
                unique case (r_cmd.op)
                    OP_APPEND: begin
                        we       = 1'b1;
                        n_strobe = 1'b1;
                    end
                    OP_ERROR: begin
                        n_strobe        = 1'b1;
                        n_result.status = 1'b1;
                    end
                    OP_QUERY: raddr = r_cmd.hi_addr;
                    default:  n_strobe = 1'b0;
                endcase
            end
            BK_LO:   raddr = r_cmd.lo_addr;
            BK_SUM2: begin
                n_strobe            = 1'b1;
                n_result.difference = n_total;
            end
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (r_state == BK_LO) begin
            r_hi_a <= rd_a;
            r_hi_b <= rd_b;
        end
        if (r_state == BK_DIFF) begin
            r_diff <= n_diff;
        end
        if (r_state == BK_SUM1) begin
            r_grp <= n_grp;
        end
        r_result <= n_result;
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_strobe <= 1'b0;
            for (int c = 0; c < ALPHABET_SIZE; c++) begin
                r_run_a[c] <= '0;
                r_run_b[c] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (r_state == BK_EXEC && r_cmd.op == OP_CLEAR) begin
                for (int c = 0; c < ALPHABET_SIZE; c++) begin
                    r_run_a[c] <= '0;
                    r_run_b[c] <= '0;
                end
            end else if (we) begin
                r_run_a <= n_run_a;
                r_run_b <= n_run_b;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== sim/range_letter_histogram_difference_test.sv =====
`timescale 1ns / 1ps

module range_letter_histogram_difference_test;
    import rlhd_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_strobe;
    t_out_item o_result;

    range_letter_histogram_difference dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Clock: 12 ns period.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Own copy of the block's state: letters of both strings, 1-based.
    logic [LTR_W-1:0] str_a [1:MAX_LENGTH];
    logic [LTR_W-1:0] str_b [1:MAX_LENGTH];
    int               str_len;

    t_in_item  pending_items[$];   // filled by the stimulus, drained by the driver
    t_out_item expected_results[$];
    int        error_count;
    bit        quiet_tail;         // no idle bursts in the last part
    int        idle_left;

    // Expected result for one accepted item; updates the string copy.
    function automatic bit predict_histogram(input t_in_item it, output t_out_item res);
        int cnt_a [ALPHABET_SIZE];
        int cnt_b [ALPHABET_SIZE];
        int sum;
        res = '0;
        case (it.mode)
            MODE_CLEAR: begin
                str_len = 0;
                return 1'b0;
            end
            MODE_APPEND: begin
                if (str_len >= MAX_LENGTH || it.letter_a >= ALPHABET_SIZE ||
                    it.letter_b >= ALPHABET_SIZE) begin
                    res.status = 1'b1;
                end else begin
                    str_len++;
                    str_a[str_len] = it.letter_a;
                    str_b[str_len] = it.letter_b;
                end
                return 1'b1;
            end
            MODE_QUERY: begin
                if (it.range_lo == 0 || it.range_lo > it.range_hi ||
                    it.range_hi > str_len) begin
                    res.status = 1'b1;
                    return 1'b1;
                end
                foreach (cnt_a[c]) begin
                    cnt_a[c] = 0;
                    cnt_b[c] = 0;
                end
                for (int p = it.range_lo; p <= it.range_hi; p++) begin
                    cnt_a[str_a[p]]++;
                    cnt_b[str_b[p]]++;
                end
                sum = 0;
                foreach (cnt_a[c])
                    if (cnt_a[c] > cnt_b[c]) sum += cnt_a[c] - cnt_b[c];
                res.difference = sum[CNT_W-1:0];
                return 1'b1;
            end
            default: return 1'b0;   // unused mode: ignored
        endcase
    endfunction

    // Driver: present the queue head; it is taken when start && !busy at an edge.
    always @(posedge i_clk) begin
        t_out_item res;
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left <= 0;
        end else begin
            if (start && !busy) begin
                if (predict_histogram(i_item, res)) expected_results.push_back(res);
                void'(pending_items.pop_front());
            end
            // Only decide a new value when the current item is not still pending.
            if (!(start && busy)) begin
                if (idle_left > 0) begin
                    start     <= 1'b0;
                    idle_left <= idle_left - 1;
                end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                    start     <= 1'b0;
                    idle_left <= $urandom_range(0, 2);
                end else if (pending_items.size() > 0) begin
                    start  <= 1'b1;
                    i_item <= pending_items[0];
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe must match the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: difference %0d status %0d",
                       o_result.difference, o_result.status);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.difference !== want.difference) begin
                    $error("difference: expected %0d, actual %0d",
                           want.difference, o_result.difference);
                    error_count++;
                end
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_result.status);
                    error_count++;
                end
            end
        end
    end

    function automatic t_in_item make_item(input logic [1:0] mode, input int la, input int lb,
                                           input int lo, input int hi);
        t_in_item it;
        it.mode     = mode;
        it.letter_a = la[LTR_W-1:0];
        it.letter_b = lb[LTR_W-1:0];
        it.range_lo = lo[POS_W-1:0];
        it.range_hi = hi[POS_W-1:0];
        return it;
    endfunction

    // Stimulus-side length tracker, so random queries mostly land in range.
    int gen_len;

    task automatic queue_item(input t_in_item it);
        if (it.mode == MODE_CLEAR) gen_len = 0;
        else if (it.mode == MODE_APPEND && gen_len < MAX_LENGTH &&
                 it.letter_a < ALPHABET_SIZE && it.letter_b < ALPHABET_SIZE) gen_len++;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained;
        while (pending_items.size() != 0 || start || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic queue_random_query;
        int lo, hi;
        if (gen_len == 0 || $urandom_range(0, 9) == 0) begin
            queue_item(make_item(MODE_QUERY, $urandom, $urandom, $urandom, $urandom));
        end else begin
            hi = $urandom_range(1, gen_len);
            lo = $urandom_range(1, hi);
            queue_item(make_item(MODE_QUERY, $urandom, $urandom, lo, hi));
        end
    endtask

    initial begin
        int n;
        error_count = 0;
        quiet_tail  = 1'b0;
        str_len     = 0;
        gen_len     = 0;
        start       = 1'b0;
        idle_left   = 0;
        i_item      = '0;
        i_rst_n     = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: queries on empty store, appends with edge letters, bad letters,
        // bad ranges, unused mode, clear.
        queue_item(make_item(MODE_QUERY, 0, 0, 1, 1));
        queue_item(make_item(MODE_QUERY, 0, 0, 0, 0));
        queue_item(make_item(MODE_APPEND, 0, 25, 0, 0));
        queue_item(make_item(MODE_APPEND, 25, 0, 2047, 2047));
        queue_item(make_item(MODE_APPEND, 26, 0, 0, 0));
        queue_item(make_item(MODE_APPEND, 0, 31, 0, 0));
        queue_item(make_item(MODE_APPEND, 31, 31, 0, 0));
        queue_item(make_item(MODE_APPEND, 3, 3, 0, 0));
        queue_item(make_item(MODE_QUERY, 31, 31, 1, 3));
        queue_item(make_item(MODE_QUERY, 0, 0, 2, 2));
        queue_item(make_item(MODE_QUERY, 0, 0, 0, 2));
        queue_item(make_item(MODE_QUERY, 0, 0, 3, 2));
        queue_item(make_item(MODE_QUERY, 0, 0, 1, 4));
        queue_item(make_item(MODE_QUERY, 0, 0, 2047, 2047));
        queue_item(make_item(2'd3, 31, 31, 2047, 2047));
        queue_item(make_item(MODE_CLEAR, 31, 31, 2047, 2047));
        queue_item(make_item(MODE_QUERY, 0, 0, 1, 1));
        queue_item(make_item(MODE_APPEND, 7, 8, 0, 0));
        queue_item(make_item(MODE_QUERY, 0, 0, 1, 1));
        // Sender holds off until every result is in.
        wait_drained();

        // Fill to capacity: all-'a' in A so a full-range query gives a large surplus
        // (non-skewed halves too), then a store-full append.
        for (int p = 0; p < MAX_LENGTH; p++)
            queue_item(make_item(MODE_APPEND, 0, (p < 8) ? 0 : 1 + $urandom_range(0, 24), 0, 0));
        queue_item(make_item(MODE_APPEND, 1, 1, 0, 0));
        queue_item(make_item(MODE_QUERY, 0, 0, 1, MAX_LENGTH));
        queue_item(make_item(MODE_QUERY, 0, 0, MAX_LENGTH, MAX_LENGTH));
        queue_item(make_item(MODE_QUERY, 0, 0, 1, MAX_LENGTH + 1));
        for (int k = 0; k < 20; k++) queue_random_query();
        queue_item(make_item(MODE_CLEAR, 0, 0, 0, 0));

        // Random: short cases of random pairs, then queries; some noise.
        n = 0;
        while (n < 400) begin
            case ($urandom_range(0, 19))
                0: begin queue_item(make_item(MODE_CLEAR, $urandom, $urandom, $urandom,
                                               $urandom)); end
                1: begin queue_item(make_item(2'd3, $urandom, $urandom, $urandom, $urandom)); end
                2: begin queue_item(make_item(MODE_APPEND, $urandom, $urandom, $urandom,
                                               $urandom)); n++; end
                3, 4, 5, 6, 7, 8, 9: begin
                    // Small alphabet subset now and then, for larger surpluses.
                    if ($urandom_range(0, 1))
                        queue_item(make_item(MODE_APPEND, $urandom_range(0, 25),
                                             $urandom_range(0, 25), $urandom, $urandom));
                    else
                        queue_item(make_item(MODE_APPEND, $urandom_range(0, 3),
                                             $urandom_range(2, 5), $urandom, $urandom));
                    n++;
                end
                default: begin queue_random_query(); n++; end
            endcase
        end
        // Last part of the run goes without idle cycles.
        while (pending_items.size() > 70) @(posedge i_clk);
        quiet_tail = 1'b1;
        wait_drained();

        if (error_count == 0) begin
            $display("** range_letter_histogram_difference: PASSED **");
        end else begin
            $display("** range_letter_histogram_difference: FAILED **");
        end
        $finish;
    end

    // Safety limit.
    initial begin
        #5ms;
        $display("** range_letter_histogram_difference: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rlhd_pkg.sv
hdl/rlhd_ram.sv
hdl/rlhd_front.sv
hdl/rlhd_fifo.sv
hdl/rlhd_back.sv
hdl/range_letter_histogram_difference.sv
sim/range_letter_histogram_difference_test.sv
